// File: rtl/core/plps_pkg.sv
// ----------------------------------------------------------------------------
// plps_pkg
// Shared types, constants and the pattern ROM of the LED pattern sequencer.
// ----------------------------------------------------------------------------
package plps_pkg;

    localparam int LED_COUNT = 2;
    localparam int LED_W     = $clog2(LED_COUNT);
    localparam int SEQ_COUNT = 9;
    localparam int SEQ_W     = 4;
    localparam logic [SEQ_W-1:0] SEQ_NONE = SEQ_W'(SEQ_COUNT);

    localparam int ROM_STEPS = 16;
    localparam int POS_ARG_W = 7;
    localparam int STEP_W    = 14;
    localparam int MS_W      = 11;

    localparam logic [1:0] KIND_STOP = 2'd0;
    localparam logic [1:0] KIND_LOOP = 2'd1;
    localparam logic [1:0] KIND_HOLD = 2'd2;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_STOP  = 2'd2;

    localparam logic [STEP_W-1:0] STEP_STOP = {KIND_STOP, 12'd0};
    localparam logic [STEP_W-1:0] STEP_LOOP = {KIND_LOOP, 12'd0};

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_TICK,
        OP_APPLY,
        OP_WALK,
        OP_RESULT
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [LED_W-1:0] led;
        logic             idle;
    } cmd_t;

    typedef struct packed {
        logic                 is_tick;
        logic                 cmd_ok;
        logic                 apply_walk;
        logic                 tick_expire;
        logic                 walk_last;
        logic [LED_COUNT-1:0] led_on;
        logic [SEQ_W-1:0]     report_seq;
    } sts_t;

    function automatic logic [STEP_W-1:0] hold_step(input logic level,
                                                   input logic [MS_W-1:0] ms);
        return {KIND_HOLD, level, ms};
    endfunction

    // Fixed blink patterns, sequence 0 has the highest priority.
    function automatic logic [STEP_W-1:0] rom_step(input logic [SEQ_W-1:0] seq,
                                                  input logic [POS_ARG_W-1:0] pos);
        logic [STEP_W-1:0] r;
        r = STEP_STOP;
        if (pos < POS_ARG_W'(ROM_STEPS))
        begin
            case (seq)
                4'd0:
                begin
                    if (pos < 7'd14)
                    begin
                        r = hold_step(~pos[0], 11'd100);
                    end
                end
                4'd1, 4'd2:
                begin
                    case (pos)
                        7'd0:    r = hold_step(1'b1, 11'd1000);
                        7'd1:    r = STEP_LOOP;
                        default: r = STEP_STOP;
                    endcase
                end
                4'd3:
                begin
                    case (pos)
                        7'd0:    r = hold_step(1'b1, 11'd200);
                        7'd1:    r = hold_step(1'b0, 11'd800);
                        7'd2:    r = STEP_LOOP;
                        default: r = STEP_STOP;
                    endcase
                end
                4'd4:
                begin
                    case (pos)
                        7'd0:    r = hold_step(1'b1, 11'd500);
                        7'd1:    r = hold_step(1'b0, 11'd500);
                        7'd2:    r = STEP_LOOP;
                        default: r = STEP_STOP;
                    endcase
                end
                4'd5:
                begin
                    case (pos)
                        7'd0:    r = hold_step(1'b1, 11'd50);
                        7'd1:    r = hold_step(1'b0, 11'd250);
                        7'd2:    r = STEP_LOOP;
                        default: r = STEP_STOP;
                    endcase
                end
                4'd6:
                begin
                    case (pos)
                        7'd0:    r = hold_step(1'b1, 11'd50);
                        7'd1:    r = hold_step(1'b0, 11'd450);
                        7'd2:    r = STEP_LOOP;
                        default: r = STEP_STOP;
                    endcase
                end
                4'd7:
                begin
                    case (pos)
                        7'd0:    r = hold_step(1'b1, 11'd50);
                        7'd1:    r = hold_step(1'b0, 11'd1950);
                        7'd2:    r = STEP_LOOP;
                        default: r = STEP_STOP;
                    endcase
                end
                4'd8:
                begin
                    case (pos)
                        7'd0:    r = hold_step(1'b1, 11'd10);
                        7'd1:    r = hold_step(1'b0, 11'd0);
                        default: r = STEP_STOP;
                    endcase
                end
                default: r = STEP_STOP;
            endcase
        end
        return r;
    endfunction

    // Lowest numbered running sequence, or none.
    function automatic logic [SEQ_W-1:0] first_running(input logic [SEQ_COUNT-1:0] run);
        logic [SEQ_W-1:0] r;
        r = SEQ_NONE;
        for (int i = SEQ_COUNT - 1; i >= 0; i--)
        begin
            if (run[i])
            begin
                r = SEQ_W'(i);
            end
        end
        return r;
    endfunction

endpackage

// File: rtl/core/plps_datapath.sv
// ----------------------------------------------------------------------------
// plps_datapath
// Per-LED sequence state, hold counters and the single step unit.
// ----------------------------------------------------------------------------
module plps_datapath
    import plps_pkg::*;
#(
    parameter int MAX_STEPS  = 16,
    parameter int TIME_WIDTH = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    input  logic [1:0]       action,
    input  logic [LED_W-1:0] led_index,
    input  logic [SEQ_W-1:0] seq_select,
    output sts_t             sts
);

    localparam int PW         = $clog2(MAX_STEPS + 1);
    localparam int WALK_LIMIT = SEQ_COUNT * (MAX_STEPS + 1) + 1;
    localparam int WCW        = $clog2(WALK_LIMIT);
    localparam logic [TIME_WIDTH-1:0] TMAX = '1;

    logic [1:0]            cap_action_reg, cap_action_next;
    logic [LED_W-1:0]      cap_led_reg, cap_led_next;
    logic [SEQ_W-1:0]      cap_seq_reg, cap_seq_next;

    logic [SEQ_COUNT-1:0]  running_reg [LED_COUNT];
    logic [SEQ_COUNT-1:0]  running_next [LED_COUNT];
    logic [PW-1:0]         pos_reg [LED_COUNT][SEQ_COUNT];
    logic [PW-1:0]         pos_next [LED_COUNT][SEQ_COUNT];
    logic [SEQ_W-1:0]      active_reg [LED_COUNT];
    logic [SEQ_W-1:0]      active_next [LED_COUNT];
    logic [TIME_WIDTH-1:0] cd_reg [LED_COUNT];
    logic [TIME_WIDTH-1:0] cd_next [LED_COUNT];
    logic [LED_COUNT-1:0]  led_on_reg, led_on_next;
    logic [WCW-1:0]        walk_cnt_reg, walk_cnt_next;

    logic                  is_tick, is_start, is_stop;
    logic [LED_W-1:0]      w_led;
    logic [SEQ_W-1:0]      w_seq;
    logic                  w_valid;
    logic [PW-1:0]         w_pos, w_pos_inc;
    logic                  w_pos_ok;
    logic [STEP_W-1:0]     w_step;
    logic [1:0]            w_kind;
    logic [MS_W-1:0]       w_time;
    logic                  w_level;
    logic [31:0]           w_time_wide;
    logic [TIME_WIDTH-1:0] w_hold;
    logic [SEQ_COUNT-1:0]  s_vec;
    logic [SEQ_W-1:0]      s_first;
    logic [SEQ_COUNT-1:0]  a_vec;
    logic [SEQ_W-1:0]      a_first;
    logic [TIME_WIDTH-1:0] t_cd;

    assign is_tick  = (cap_action_reg == ACT_TICK);
    assign is_start = (cap_action_reg == ACT_START);
    assign is_stop  = (cap_action_reg == ACT_STOP);

    // Step unit: one step of the active sequence of the selected LED.
    assign w_led       = is_tick ? cmd.led : cap_led_reg;
    assign w_seq       = active_reg[w_led];
    assign w_valid     = (w_seq < SEQ_NONE);
    assign w_pos       = pos_reg[w_led][w_seq];
    assign w_pos_ok    = (w_pos < PW'(MAX_STEPS));
    assign w_pos_inc   = w_pos_ok ? (w_pos + PW'(1)) : w_pos;
    assign w_step      = w_pos_ok ? rom_step(w_seq, POS_ARG_W'(w_pos)) : STEP_STOP;
    assign w_kind      = w_step[STEP_W-1 -: 2];
    assign w_level     = w_step[MS_W];
    assign w_time      = w_step[MS_W-1:0];
    assign w_time_wide = 32'(w_time);
    assign w_hold      = (w_time_wide > 32'(TMAX)) ? TMAX : TIME_WIDTH'(w_time_wide);

    always_comb
    begin
        s_vec         = running_reg[w_led];
        s_vec[w_seq]  = 1'b0;
        a_vec         = running_reg[cap_led_reg];
        a_vec[cap_seq_reg] = is_start;
    end

    assign s_first = first_running(s_vec);
    assign a_first = first_running(a_vec);
    assign t_cd    = cd_reg[cmd.led];

    assign sts.is_tick     = is_tick;
    assign sts.cmd_ok      = (is_start || is_stop) && (cap_seq_reg < SEQ_NONE);
    assign sts.apply_walk  = is_stop || (a_first == cap_seq_reg);
    assign sts.tick_expire = (t_cd == TIME_WIDTH'(1));
    assign sts.walk_last   = !w_valid
                           || ((w_kind == KIND_HOLD) && (w_time != '0))
                           || (walk_cnt_reg == WCW'(WALK_LIMIT - 1));
    assign sts.led_on      = led_on_reg;
    assign sts.report_seq  = active_reg[cap_led_reg];

    always_comb
    begin
        cap_action_next = cap_action_reg;
        cap_led_next    = cap_led_reg;
        cap_seq_next    = cap_seq_reg;
        running_next    = running_reg;
        pos_next        = pos_reg;
        active_next     = active_reg;
        cd_next         = cd_reg;
        led_on_next     = led_on_reg;
        walk_cnt_next   = walk_cnt_reg;
        case (cmd.op)
            OP_CAPTURE:
            begin
                cap_action_next = action;
                cap_led_next    = led_index;
                cap_seq_next    = seq_select;
            end
            OP_TICK:
            begin
                if (t_cd != '0)
                begin
                    cd_next[cmd.led] = t_cd - TIME_WIDTH'(1);
                end
                walk_cnt_next = '0;
            end
            OP_APPLY:
            begin
                running_next[cap_led_reg]           = a_vec;
                pos_next[cap_led_reg][cap_seq_reg]  = '0;
                active_next[cap_led_reg]            = a_first;
                led_on_next[cap_led_reg]            = 1'b0;
                walk_cnt_next                       = '0;
            end
            OP_WALK:
            begin
                if (w_valid)
                begin
                    walk_cnt_next = walk_cnt_reg + WCW'(1);
                    case (w_kind)
                        KIND_LOOP:
                        begin
                            pos_next[w_led][w_seq] = '0;
                        end
                        KIND_HOLD:
                        begin
                            pos_next[w_led][w_seq] = w_pos_inc;
                            led_on_next[w_led]     = w_level;
                            if (w_time != '0)
                            begin
                                cd_next[w_led] = w_hold;
                            end
                        end
                        default:
                        begin
                            // Stop marker: the sequence ends and priority is re-resolved.
                            running_next[w_led]    = s_vec;
                            pos_next[w_led][w_seq] = '0;
                            active_next[w_led]     = s_first;
                            led_on_next[w_led]     = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < LED_COUNT; l++)
            begin
                running_reg[l] <= '0;
                active_reg[l]  <= SEQ_NONE;
                cd_reg[l]      <= '0;
                for (int s = 0; s < SEQ_COUNT; s++)
                begin
                    pos_reg[l][s] <= '0;
                end
            end
            led_on_reg   <= '0;
            walk_cnt_reg <= '0;
        end
        else
        begin
            running_reg  <= running_next;
            pos_reg      <= pos_next;
            active_reg   <= active_next;
            cd_reg       <= cd_next;
            led_on_reg   <= led_on_next;
            walk_cnt_reg <= walk_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cap_action_reg <= cap_action_next;
        cap_led_reg    <= cap_led_next;
        cap_seq_reg    <= cap_seq_next;
    end

endmodule

// File: rtl/core/plps_ctrl.sv
// ----------------------------------------------------------------------------
// plps_ctrl
// Sequencer state machine that orders the datapath operations for one item.
// ----------------------------------------------------------------------------
module plps_ctrl
    import plps_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic out_busy,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_DISPATCH = 6'b000010,
        S_TICK     = 6'b000100,
        S_APPLY    = 6'b001000,
        S_WALK     = 6'b010000,
        S_RESULT   = 6'b100000
    } state_t;

    localparam logic [LED_W-1:0] LED_LAST = LED_W'(LED_COUNT - 1);

    state_t           state_reg, state_next;
    logic [LED_W-1:0] led_cnt_reg, led_cnt_next;

    always_comb
    begin
        state_next   = state_reg;
        led_cnt_next = led_cnt_reg;
        cmd.op       = OP_NONE;
        cmd.led      = led_cnt_reg;
        cmd.idle     = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_CAPTURE;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                led_cnt_next = '0;
                if (sts.is_tick)
                begin
                    state_next = S_TICK;
                end
                else if (sts.cmd_ok)
                begin
                    state_next = S_APPLY;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_TICK:
            begin
                cmd.op = OP_TICK;
                if (sts.tick_expire)
                begin
                    state_next = S_WALK;
                end
                else if (led_cnt_reg == LED_LAST)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    led_cnt_next = led_cnt_reg + LED_W'(1);
                end
            end
            S_APPLY:
            begin
                cmd.op     = OP_APPLY;
                state_next = sts.apply_walk ? S_WALK : S_RESULT;
            end
            S_WALK:
            begin
                cmd.op = OP_WALK;
                if (sts.walk_last)
                begin
                    if (sts.is_tick && (led_cnt_reg != LED_LAST))
                    begin
                        led_cnt_next = led_cnt_reg + LED_W'(1);
                        state_next   = S_TICK;
                    end
                    else
                    begin
                        state_next = S_RESULT;
                    end
                end
            end
            S_RESULT:
            begin
                if (!out_busy)
                begin
                    cmd.op     = OP_RESULT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            led_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            led_cnt_reg <= led_cnt_next;
        end
    end

endmodule

// File: rtl/core/priority_led_pattern_sequencer_top.sv
// ----------------------------------------------------------------------------
// priority_led_pattern_sequencer_top
// Priority LED blink pattern engine: ticks, start and stop items in, one
// result item with pin levels and the reported active sequence out.
// ----------------------------------------------------------------------------
// From the accepting edge an item is captured and dispatched; a tick then sweeps
// every LED, a valid start or stop is applied, and steps are walked where needed,
// before the result; a walk is bounded by SEQ_COUNT*(MAX_STEPS+1)+1 steps.
// Throughput: one item at a time; the next is taken once the engine is idle again,
// later while an earlier result still stalls in the output register.
// Reset (rst_n, asynchronous, active low): all sequences stopped, no active
// sequence, counters zero, LEDs off and active_low_pins set to 1.
// ----------------------------------------------------------------------------
module priority_led_pattern_sequencer_top
    import plps_pkg::*;
#(
    parameter int MAX_STEPS  = 16,
    parameter int TIME_WIDTH = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    // Input channel: one item per tick, start or stop.
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           action,
    input  logic [LED_W-1:0]     led_index,
    input  logic [SEQ_W-1:0]     seq_select,

    // Output channel: one result item per input item.
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [LED_COUNT-1:0] led_levels,
    output logic [SEQ_W-1:0]     active_seq,

    // Polarity register write port.
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data
);

    cmd_t                 cmd;
    sts_t                 sts;
    logic                 out_busy;

    logic                 active_low_pins_reg, active_low_pins_next;
    logic                 out_valid_reg, out_valid_next;
    logic [LED_COUNT-1:0] led_levels_reg, led_levels_next;
    logic [SEQ_W-1:0]     active_seq_reg, active_seq_next;

    // The engine takes a new item only when the state machine is idle. A
    // finished result can still be waiting in the output register then, so
    // the next item is already being worked on while the sink stalls.
    assign in_stall = !cmd.idle;
    assign out_busy = out_valid_reg && out_stall;

    plps_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_busy (out_busy),
        .sts      (sts),
        .cmd      (cmd)
    );

    plps_datapath
    #(
        .MAX_STEPS  (MAX_STEPS),
        .TIME_WIDTH (TIME_WIDTH)
    )
    u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .action     (action),
        .led_index  (led_index),
        .seq_select (seq_select),
        .sts        (sts)
    );

    // The result is captured once all work for the item is done. Pin levels
    // follow the polarity register as it stands at that moment.
    always_comb
    begin
        active_low_pins_next = cfg_wr_en ? cfg_wr_data : active_low_pins_reg;
        out_valid_next       = out_valid_reg && out_stall;
        led_levels_next      = led_levels_reg;
        active_seq_next      = active_seq_reg;
        if (cmd.op == OP_RESULT)
        begin
            out_valid_next  = 1'b1;
            led_levels_next = sts.led_on ^ {LED_COUNT{active_low_pins_reg}};
            active_seq_next = sts.report_seq;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_low_pins_reg <= 1'b1;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            active_low_pins_reg <= active_low_pins_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        led_levels_reg <= led_levels_next;
        active_seq_reg <= active_seq_next;
    end

    assign out_valid  = out_valid_reg;
    assign led_levels = led_levels_reg;
    assign active_seq = active_seq_reg;

endmodule

// File: rtl/core/plps_checker.sv
// ----------------------------------------------------------------------------
// plps_checker
// Port-level checks of the LED pattern sequencer, bound to its top level.
// ----------------------------------------------------------------------------
module plps_checker
    import plps_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [LED_COUNT-1:0] led_levels,
    input logic [SEQ_W-1:0]     active_seq
);

    // A stalled result item holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(led_levels) && $stable(active_seq))
        else $error("stalled result item changed");

    // The reported sequence is a valid number or the none code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (active_seq <= SEQ_NONE))
        else $error("reported sequence out of range");

    // An accepted item keeps the engine busy in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("engine took an item without going busy");

    // A new result only appears while an item was being worked on.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result item appeared while idle");

endmodule

bind priority_led_pattern_sequencer_top plps_checker u_plps_checker (.*);

// File: tb/priority_led_pattern_sequencer_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// priority_led_pattern_sequencer_top_tb
// Self-checking bench for the priority LED pattern sequencer. A scoreboard
// class holds a cycle-free model of the blink engine. It predicts the pin
// levels and the reported sequence for every accepted item, and it compares
// each returned result in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module priority_led_pattern_sequencer_top_tb;
    import plps_pkg::*;

    // Geometry of the pattern engine as built here.
    localparam int STEP_SLOTS = 16;
    localparam int HOLD_W     = 16;
    localparam int WALK_LIMIT = SEQ_COUNT * (STEP_SLOTS + 1) + 1;

    // The action code that the block must ignore.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Worst item is a tick that walks both LEDs for the full walk limit.
    localparam int SETTLE_CYCLES = 2 * (WALK_LIMIT + 8) + 16;
    // Generous ceiling: every item taking its longest walk, its longest gap
    // and its longest output stall, several times over.
    localparam int CYCLE_LIMIT   = 3_000_000;

    typedef struct packed {
        logic [LED_COUNT-1:0] levels;
        logic [SEQ_W-1:0]     seq;
    } pin_report_t;

    // ------------------------------------------------------------------------
    // Scoreboard. It keeps its own copy of the run flags, step positions,
    // hold countdowns and LED states, and a queue of predicted pin reports.
    // ------------------------------------------------------------------------
    class blink_scoreboard;
        bit                running[LED_COUNT][SEQ_COUNT];
        logic [4:0]        position[LED_COUNT][SEQ_COUNT];
        logic [SEQ_W-1:0]  shown_seq[LED_COUNT];
        logic [HOLD_W-1:0] hold_left[LED_COUNT];
        bit                lit[LED_COUNT];
        bit                invert;
        pin_report_t       expected_reports[$];
        int                errors;

        function new();
            int l;
            int s;
            for (l = 0; l < LED_COUNT; l++)
            begin
                for (s = 0; s < SEQ_COUNT; s++)
                begin
                    running[l][s]  = 1'b0;
                    position[l][s] = '0;
                end
                shown_seq[l] = SEQ_NONE;
                hold_left[l] = '0;
                lit[l]       = 1'b0;
            end
            invert = 1'b1;
            errors = 0;
        endfunction

        function void set_polarity(input bit value);
            invert = value;
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        // Pattern table: sequence 0 is seven blinks of 100 ms, then the list
        // ends. Sequences 1 to 7 are an on hold, an off hold (except 1 and 2)
        // and a loop. Sequence 8 is a 10 ms flash, an off hold of no time and
        // the end of the list.
        function void fetch_step(input int seq, input int pos, output logic [1:0] kind,
                                 output bit level, output int ms);
            int on_ms[SEQ_COUNT];
            int off_ms[SEQ_COUNT];
            on_ms  = '{0, 1000, 1000, 200, 500, 50, 50, 50, 10};
            off_ms = '{0, 0, 0, 800, 500, 250, 450, 1950, 0};
            kind   = KIND_STOP;
            level  = 1'b0;
            ms     = 0;
            if (seq >= SEQ_COUNT || pos >= STEP_SLOTS)
            begin
                return;
            end
            if (seq == 0)
            begin
                if (pos < 14)
                begin
                    kind  = KIND_HOLD;
                    level = (pos % 2) == 0;
                    ms    = 100;
                end
            end
            else if (pos == 0)
            begin
                kind  = KIND_HOLD;
                level = 1'b1;
                ms    = on_ms[seq];
            end
            else if (pos == 1 && (seq == 1 || seq == 2))
            begin
                kind = KIND_LOOP;
            end
            else if (pos == 1)
            begin
                kind = KIND_HOLD;
                ms   = off_ms[seq];
            end
            else if (pos == 2 && seq != 8)
            begin
                kind = KIND_LOOP;
            end
        endfunction

        // Choose the highest priority running sequence; the LED goes dark.
        function void pick_active(input int l);
            int s;
            shown_seq[l] = SEQ_NONE;
            lit[l]       = 1'b0;
            for (s = SEQ_COUNT - 1; s >= 0; s--)
            begin
                if (running[l][s])
                begin
                    shown_seq[l] = SEQ_W'(s);
                end
            end
        endfunction

        // Step the active sequence until a timed hold or until none runs.
        function void advance_led(input int l);
            int         guard;
            int         p;
            int         ms;
            logic [1:0] kind;
            bit         level;
            for (guard = 0; guard < WALK_LIMIT; guard++)
            begin
                p = shown_seq[l];
                if (p >= SEQ_COUNT)
                begin
                    return;
                end
                fetch_step(p, position[l][p], kind, level, ms);
                if (position[l][p] < STEP_SLOTS)
                begin
                    position[l][p]++;
                end
                if (kind == KIND_LOOP)
                begin
                    position[l][p] = '0;
                end
                else if (kind == KIND_HOLD)
                begin
                    lit[l] = level;
                    if (ms != 0)
                    begin
                        hold_left[l] = HOLD_W'(ms);
                        return;
                    end
                end
                else
                begin
                    running[l][p]  = 1'b0;
                    position[l][p] = '0;
                    pick_active(l);
                end
            end
        endfunction

        function void note_item(input logic [1:0] act, input logic [LED_W-1:0] led,
                                input logic [SEQ_W-1:0] seq);
            pin_report_t r;
            int          i;
            int          l;
            int          s;
            l = led;
            s = seq;
            if (act == ACT_TICK)
            begin
                for (i = 0; i < LED_COUNT; i++)
                begin
                    if (hold_left[i] != 0)
                    begin
                        hold_left[i]--;
                        if (hold_left[i] == 0)
                        begin
                            advance_led(i);
                        end
                    end
                end
            end
            else if ((act == ACT_START || act == ACT_STOP) && l < LED_COUNT
                     && s < SEQ_COUNT)
            begin
                running[l][s]  = (act == ACT_START);
                position[l][s] = '0;
                pick_active(l);
                if (act == ACT_STOP || shown_seq[l] == s)
                begin
                    advance_led(l);
                end
            end
            for (i = 0; i < LED_COUNT; i++)
            begin
                r.levels[i] = lit[i] ^ invert;
            end
            r.seq = (l < LED_COUNT) ? shown_seq[l] : SEQ_NONE;
            expected_reports.push_back(r);
        endfunction

        function void check_result(input logic [LED_COUNT-1:0] levels,
                                   input logic [SEQ_W-1:0] seq);
            pin_report_t want;
            if (expected_reports.size() == 0)
            begin
                $error("result with no item outstanding: led_levels=%0h active_seq=%0d",
                       levels, seq);
                errors++;
                return;
            end
            want = expected_reports.pop_front();
            if (levels !== want.levels)
            begin
                $error("led_levels: expected %0h, got %0h", want.levels, levels);
                errors++;
            end
            if (seq !== want.seq)
            begin
                $error("active_seq: expected %0d, got %0d", want.seq, seq);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                 clk;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 in_stall;
    logic [1:0]           action      = ACT_TICK;
    logic [LED_W-1:0]     led_index   = '0;
    logic [SEQ_W-1:0]     seq_select  = '0;
    logic                 out_valid;
    logic                 out_stall   = 1'b0;
    logic [LED_COUNT-1:0] led_levels;
    logic [SEQ_W-1:0]     active_seq;
    logic                 cfg_wr_en   = 1'b0;
    logic                 cfg_wr_data = 1'b0;

    blink_scoreboard sb;

    // When clear, neither side inserts gaps or stalls, so the block sees
    // back-to-back items and an always-ready receiver.
    bit idle_on = 1'b1;

    priority_led_pattern_sequencer_top #(
        .MAX_STEPS  (STEP_SLOTS),
        .TIME_WIDTH (HOLD_W)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .led_index   (led_index),
        .seq_select  (seq_select),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .led_levels  (led_levels),
        .active_seq  (active_seq),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // The watchdog ends a run that has hung.
    initial
    begin
        int cycles;
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("priority_led_pattern_sequencer_top_tb NOT OK");
                $finish;
            end
        end
    end

    // Idle lengths: mostly none or a few cycles, now and then a long pause.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Receiver. A result counts at an edge where out_valid is high and
    // out_stall is low; both are sampled before the edge updates them. The
    // stall for the next cycle is chosen at the same edge.
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall == 1'b0)
            begin
                sb.check_result(led_levels, active_seq);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall  <= 1'b0;
                stall_left = idle_on ? pick_gap() : 0;
            end
        end
    end

    // Presents one item and holds it until the block takes it. When the item
    // follows with no gap, in_valid simply stays high and only the payload
    // moves, so valid never drops and rises in one time step.
    task automatic send_item(input logic [1:0] act, input logic [LED_W-1:0] led,
                             input logic [SEQ_W-1:0] seq);
        int gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        led_index  <= led;
        seq_select <= seq;
        do
        begin
            @(posedge clk);
        end
        while (in_stall !== 1'b0);
        sb.note_item(act, led, seq);
    endtask

    // Waits until every predicted result is back, then lets the block
    // settle so that no walk is still under way.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // The polarity register is only written while the block is idle.
    task automatic write_polarity(input logic value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_polarity(value);
    endtask

    // Random traffic. Shares are per mille. Starts and stops name a real
    // sequence most of the time; the remainder is noise: the unused action
    // code or a sequence number past the table. With keep_top set, sequence
    // 0 is never started or stopped, so once running it can play its whole
    // list to the end.
    task automatic run_phase(input int count, input int tick_pm, input bit keep_top);
        int               n;
        int               r;
        int               rest;
        logic [1:0]       act;
        logic [LED_W-1:0] led;
        logic [SEQ_W-1:0] seq;
        rest = 1000 - tick_pm;
        for (n = 0; n < count; n++)
        begin
            r   = $urandom_range(999);
            led = LED_W'($urandom_range(LED_COUNT - 1));
            if (r < tick_pm)
            begin
                act = ACT_TICK;
                seq = SEQ_W'($urandom_range(15));
            end
            else if (r < tick_pm + rest * 8 / 10)
            begin
                act = (r < tick_pm + rest * 4 / 10) ? ACT_START : ACT_STOP;
                seq = SEQ_W'($urandom_range(keep_top ? 1 : 0, SEQ_COUNT - 1));
            end
            else if ($urandom_range(1) == 0)
            begin
                act = ACT_UNUSED;
                seq = SEQ_W'($urandom_range(15));
            end
            else
            begin
                act = ($urandom_range(1) == 0) ? ACT_START : ACT_STOP;
                seq = SEQ_W'($urandom_range(SEQ_COUNT, 15));
            end
            send_item(act, led, seq);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        int n;
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with the pins still active low as after reset.
        // Noise first: the unused action and out of range sequence numbers
        // must leave all state alone but still return a report.
        send_item(ACT_UNUSED, 1'b0, 4'd0);
        send_item(ACT_START, 1'b1, 4'd15);
        send_item(ACT_STOP, 1'b0, SEQ_NONE);

        // LED 0 runs the short flash, LED 1 the top blink pattern. A start
        // of a lower sequence on LED 1 must not take over its display.
        send_item(ACT_START, 1'b0, 4'd8);
        send_item(ACT_START, 1'b1, 4'd0);
        send_item(ACT_START, 1'b1, 4'd5);

        // Ten ticks end the flash on LED 0: the off hold of no time is passed
        // at once and the list ends, leaving nothing running.
        for (n = 0; n < 10; n++)
        begin
            send_item(ACT_TICK, LED_W'(n % 2), SEQ_W'(n));
        end

        // Stopping the top pattern mid-hold hands LED 1 to sequence 5, which
        // reloads the countdown at once.
        send_item(ACT_STOP, 1'b1, 4'd0);

        // Start then stop on LED 0: the countdown left behind keeps running
        // with nothing active.
        send_item(ACT_START, 1'b0, 4'd7);
        send_item(ACT_STOP, 1'b0, 4'd7);

        // A higher start preempts a lower running one.
        send_item(ACT_START, 1'b0, 4'd1);
        send_item(ACT_START, 1'b0, 4'd0);

        // Stopping a sequence that is not running still recomputes the LED
        // and advances the active sequence one step at once.
        send_item(ACT_STOP, 1'b1, 4'd3);

        // Random part, active-high pins, with idling on both sides.
        write_polarity(1'b0);
        run_phase(100, 600, 1'b0);

        // Active-low pins, back-to-back items and a receiver that never
        // stalls.
        write_polarity(1'b1);
        idle_on = 1'b0;
        run_phase(100, 850, 1'b0);

        // Active-high pins again. Both LEDs get the top pattern, and a long
        // run of ticks lets it play through to the end of its list while
        // lower sequences come and go underneath.
        write_polarity(1'b0);
        idle_on = 1'b1;
        send_item(ACT_START, 1'b0, 4'd0);
        send_item(ACT_START, 1'b1, 4'd0);
        run_phase(1450, 990, 1'b1);

        wait_drained();
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("priority_led_pattern_sequencer_top_tb OK");
        end
        else
        begin
            $display("priority_led_pattern_sequencer_top_tb NOT OK");
        end
        $finish;
    end

endmodule

// File: priority_led_pattern_sequencer_top.f
rtl/core/plps_pkg.sv
rtl/core/plps_datapath.sv
rtl/core/plps_ctrl.sv
rtl/core/priority_led_pattern_sequencer_top.sv
rtl/core/plps_checker.sv
tb/priority_led_pattern_sequencer_top_tb.sv
